/* hdl/tocm_pkg.sv */
package tocm_pkg;

  localparam int TIME_W    = 64;
  localparam int RISE_W    = 32;
  localparam int DUR_W     = 32;
  localparam int RING_W    = 16;
  localparam int PAYLOAD_W = 32;
  localparam int SLOT_W    = 3;
  localparam int CMD_W     = 2;
  localparam int CH_IDX_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [TIME_W-1:0]    begin_time;
    logic [RISE_W-1:0]    rise_time;
    logic [DUR_W-1:0]     duration;
    logic [RING_W-1:0]    ring_count;
    logic [PAYLOAD_W-1:0] payload;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic                found;
    logic                dropped;
    logic [SLOT_W-1:0]   channel;
    entry_t              ev;
  } result_t;

  typedef struct packed {
    logic                push;
    logic                pop;
    logic                clear;
    logic [CH_IDX_W-1:0] idx;
  } ptr_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } ptr_stat_t;

endpackage

/* hdl/tocm_ram.sv */
module tocm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/tocm_ptrs.sv */
module tocm_ptrs #(
  parameter int CHANNELS    = 8,
  parameter int QUEUE_DEPTH = 64,
  localparam int LW = $clog2(QUEUE_DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tocm_pkg::ptr_ctrl_t  ctrl_i,
  output tocm_pkg::ptr_stat_t  stat_o,
  output logic [LW-1:0]        head_low_o,
  output logic [LW-1:0]        tail_low_o
);
  import tocm_pkg::*;

  localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [LW-1:0] head_low_q  [CHANNELS];
  logic [LW-1:0] tail_low_q  [CHANNELS];
  logic          head_wrap_q [CHANNELS];
  logic          tail_wrap_q [CHANNELS];

  logic [IW-1:0] idx;
  logic [LW-1:0] head_nxt, tail_nxt;
  logic          head_last, tail_last;

  assign idx       = ctrl_i.idx[IW-1:0];
  assign head_last = (head_low_q[idx] == LW'(QUEUE_DEPTH - 1));
  assign tail_last = (tail_low_q[idx] == LW'(QUEUE_DEPTH - 1));
  assign head_nxt  = head_last ? '0 : head_low_q[idx] + LW'(1);
  assign tail_nxt  = tail_last ? '0 : tail_low_q[idx] + LW'(1);

  assign head_low_o   = head_low_q[idx];
  assign tail_low_o   = tail_low_q[idx];
  assign stat_o.empty = (head_low_q[idx] == tail_low_q[idx]) &&
                        (head_wrap_q[idx] == tail_wrap_q[idx]);
  assign stat_o.full  = (head_low_q[idx] == tail_low_q[idx]) &&
                        (head_wrap_q[idx] != tail_wrap_q[idx]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        head_low_q[c]  <= '0;
        tail_low_q[c]  <= '0;
        head_wrap_q[c] <= 1'b0;
        tail_wrap_q[c] <= 1'b0;
      end
    end else if (ctrl_i.clear) begin
      for (int c = 0; c < CHANNELS; c++) begin
        head_low_q[c]  <= '0;
        tail_low_q[c]  <= '0;
        head_wrap_q[c] <= 1'b0;
        tail_wrap_q[c] <= 1'b0;
      end
    end else begin
      if (ctrl_i.push) begin
        tail_low_q[idx] <= tail_nxt;
        if (tail_last) begin
          tail_wrap_q[idx] <= ~tail_wrap_q[idx];
        end
      end
      if (ctrl_i.pop) begin
        head_low_q[idx] <= head_nxt;
        if (head_last) begin
          head_wrap_q[idx] <= ~head_wrap_q[idx];
        end
      end
    end
  end

endmodule

/* hdl/timestamp_ordered_channel_merge.sv */
// Per-channel event queues merged by start time. A push, a clear or a reserved command
// puts its result item into the output register at once; a push to a full queue or to a
// channel outside the configured range comes back with dropped set. A pop scans the
// channels: the event memory has one read port, so the sequencer reads one channel head
// per cycle and a single 64-bit comparator keeps the earliest so far, lowest channel on
// ties. The block takes no new item during a pop. The event memory is not cleared; a
// clear only resets the queue pointers.
module timestamp_ordered_channel_merge #(
  parameter int CHANNELS    = 8,
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [tocm_pkg::CMD_W-1:0]     cmd_i,
  input  logic [tocm_pkg::SLOT_W-1:0]    channel_slot_i,
  input  logic [tocm_pkg::TIME_W-1:0]    begin_time_i,
  input  logic [tocm_pkg::RISE_W-1:0]    rise_time_i,
  input  logic [tocm_pkg::DUR_W-1:0]     duration_i,
  input  logic [tocm_pkg::RING_W-1:0]    ring_count_i,
  input  logic [tocm_pkg::PAYLOAD_W-1:0] payload_tag_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           found_o,
  output logic                           dropped_o,
  output logic [tocm_pkg::SLOT_W-1:0]    out_channel_o,
  output logic [tocm_pkg::TIME_W-1:0]    out_begin_time_o,
  output logic [tocm_pkg::RISE_W-1:0]    out_rise_time_o,
  output logic [tocm_pkg::DUR_W-1:0]     out_duration_o,
  output logic [tocm_pkg::RING_W-1:0]    out_ring_count_o,
  output logic [tocm_pkg::PAYLOAD_W-1:0] out_payload_o
);
  import tocm_pkg::*;

  localparam int LW    = $clog2(QUEUE_DEPTH);
  localparam int IW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SW    = $clog2(CHANNELS + 1);
  localparam int DEPTH = CHANNELS * QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  state_e        state_q, state_d;
  logic [SW-1:0] scan_q, scan_d;
  logic          pend_q, pend_d;
  logic [IW-1:0] pend_ch_q, pend_ch_d;
  logic          have_q, have_d;
  logic [IW-1:0] best_ch_q, best_ch_d;
  entry_t        best_q, best_d;
  logic          out_valid_q, out_valid_d;
  result_t       res_q, res_d;
  logic          out_load;

  ptr_ctrl_t     pctrl;
  ptr_stat_t     pstat;
  logic [LW-1:0] head_low, tail_low;
  logic [IW-1:0] sel_ch;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  entry_t        ram_wdata, ram_rdata;

  logic          in_acc;
  logic          out_free;
  logic          slot_bad;
  logic          scan_live;
  logic          earlier;
  cmd_e          cmd;

  assign cmd       = cmd_e'(cmd_i);
  assign out_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_acc    = in_valid_i && in_ready_o;
  assign slot_bad  = (32'(channel_slot_i) >= CHANNELS);
  assign scan_live = (32'(scan_q) < CHANNELS);
  assign earlier   = !have_q || (ram_rdata.begin_time < best_q.begin_time);

  tocm_ptrs #(
    .CHANNELS    (CHANNELS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ptrs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (pctrl),
    .stat_o     (pstat),
    .head_low_o (head_low),
    .tail_low_o (tail_low)
  );

  tocm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign ram_wdata.begin_time = begin_time_i;
  assign ram_wdata.rise_time  = rise_time_i;
  assign ram_wdata.duration   = duration_i;
  assign ram_wdata.ring_count = ring_count_i;
  assign ram_wdata.payload    = payload_tag_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (cmd == CMD_POP)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (32'(scan_q) == CHANNELS) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    sel_ch      = IW'(channel_slot_i);
    pctrl       = '0;
    ram_we      = 1'b0;
    scan_d      = scan_q;
    pend_d      = 1'b0;
    pend_ch_d   = pend_ch_q;
    have_d      = have_q;
    best_ch_d   = best_ch_q;
    best_d      = best_q;
    out_load    = 1'b0;
    res_d       = '0;
    unique case (state_q)
      ST_IDLE: begin
        scan_d = '0;
        have_d = 1'b0;
        if (in_acc) begin
          case (cmd)
            CMD_PUSH: begin
              out_load = 1'b1;
              if (slot_bad || pstat.full) begin
                res_d.dropped = 1'b1;
              end else begin
                ram_we     = 1'b1;
                pctrl.push = 1'b1;
              end
            end
            CMD_POP: ;
            CMD_CLEAR: begin
              out_load    = 1'b1;
              pctrl.clear = 1'b1;
            end
            default: out_load = 1'b1;
          endcase
        end
      end
      ST_SCAN: begin
        sel_ch    = scan_q[IW-1:0];
        pend_d    = scan_live && !pstat.empty;
        pend_ch_d = scan_q[IW-1:0];
        scan_d    = scan_q + SW'(1);
        if (pend_q && earlier) begin
          have_d    = 1'b1;
          best_ch_d = pend_ch_q;
          best_d    = ram_rdata;
        end
      end
      ST_FIN: begin
        sel_ch = best_ch_q;
        if (out_free) begin
          out_load  = 1'b1;
          pctrl.pop = have_q;
          if (have_q) begin
            res_d.found   = 1'b1;
            res_d.channel = SLOT_W'(best_ch_q);
            res_d.ev      = best_q;
          end
        end
      end
      default: ;
    endcase
    pctrl.idx = CH_IDX_W'(sel_ch);
  end

  always_comb begin
    if (state_q == ST_IDLE) begin
      ram_addr = AW'(sel_ch) * AW'(QUEUE_DEPTH) + AW'(tail_low);
    end else begin
      ram_addr = AW'(sel_ch) * AW'(QUEUE_DEPTH) + AW'(head_low);
    end
  end

  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      pend_q      <= pend_d;
      have_q      <= have_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_ch_q <= pend_ch_d;
    best_ch_q <= best_ch_d;
    best_q    <= best_d;
    if (out_load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign found_o          = res_q.found;
  assign dropped_o        = res_q.dropped;
  assign out_channel_o    = res_q.channel;
  assign out_begin_time_o = res_q.ev.begin_time;
  assign out_rise_time_o  = res_q.ev.rise_time;
  assign out_duration_o   = res_q.ev.duration;
  assign out_ring_count_o = res_q.ev.ring_count;
  assign out_payload_o    = res_q.ev.payload;

endmodule

/* hdl/tocm_checker.sv */
module tocm_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic [tocm_pkg::CMD_W-1:0]     cmd_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic                           found_o,
  input logic                           dropped_o,
  input logic [tocm_pkg::SLOT_W-1:0]    out_channel_o,
  input logic [tocm_pkg::TIME_W-1:0]    out_begin_time_o
);
  import tocm_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_begin_time_o))
    else $error("result item changed while stalled");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(found_o && dropped_o))
    else $error("found and dropped both set");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> out_channel_o == '0 && out_begin_time_o == '0)
    else $error("result without event carries data");

  a_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && cmd_i == CMD_POP |=> !in_ready_o)
    else $error("item taken during pop scan");

  a_quick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && cmd_i != CMD_POP |=> out_valid_o)
    else $error("single-cycle command produced no result");

endmodule

bind timestamp_ordered_channel_merge tocm_checker u_tocm_checker (.*);

/* tb/timestamp_ordered_channel_merge_tb.sv */
module timestamp_ordered_channel_merge_tb;
  import tocm_pkg::*;

  localparam int NCH         = 8;
  localparam int QDEPTH      = 64;
  localparam int PTR_W       = $clog2(QDEPTH) + 1;
  localparam int IDLE_PCT    = 18;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RAND_ITEMS  = 750;

  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot;
    entry_t            ev;
    logic              hold;
  } bus_item_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [CMD_W-1:0]     cmd_drv   = '0;
  logic [SLOT_W-1:0]    slot_drv  = '0;
  logic [TIME_W-1:0]    time_drv  = '0;
  logic [RISE_W-1:0]    rise_drv  = '0;
  logic [DUR_W-1:0]     dur_drv   = '0;
  logic [RING_W-1:0]    ring_drv  = '0;
  logic [PAYLOAD_W-1:0] tag_drv   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 res_found;
  logic                 res_dropped;
  logic [SLOT_W-1:0]    res_channel;
  logic [TIME_W-1:0]    res_time;
  logic [RISE_W-1:0]    res_rise;
  logic [DUR_W-1:0]     res_dur;
  logic [RING_W-1:0]    res_ring;
  logic [PAYLOAD_W-1:0] res_payload;

  bus_item_t pending_items[$];
  result_t   expected_results[$];
  bus_item_t cur_item;
  result_t   want_res;

  entry_t           ev_mem   [NCH][QDEPTH];
  logic [PTR_W-1:0] head_ptr [NCH];
  logic [PTR_W-1:0] tail_ptr [NCH];

  int unsigned cycle_cnt    = 0;
  int unsigned accepted_cnt = 0;
  int unsigned driven_cnt   = 0;
  int unsigned res_cnt      = 0;
  int unsigned err_cnt      = 0;
  int unsigned gen_cnt      = 0;
  int unsigned n_push = 0, n_drop = 0, n_found = 0, n_empty_pop = 0;
  int unsigned n_clear = 0, n_rsvd = 0;

  logic quiet_window;
  assign quiet_window = (cycle_cnt >= 1500) && (cycle_cnt < 3500);

  timestamp_ordered_channel_merge #(
    .CHANNELS    (NCH),
    .QUEUE_DEPTH (QDEPTH)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .cmd_i            (cmd_drv),
    .channel_slot_i   (slot_drv),
    .begin_time_i     (time_drv),
    .rise_time_i      (rise_drv),
    .duration_i       (dur_drv),
    .ring_count_i     (ring_drv),
    .payload_tag_i    (tag_drv),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .found_o          (res_found),
    .dropped_o        (res_dropped),
    .out_channel_o    (res_channel),
    .out_begin_time_o (res_time),
    .out_rise_time_o  (res_rise),
    .out_duration_o   (res_dur),
    .out_ring_count_o (res_ring),
    .out_payload_o    (res_payload)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Merge predictor: applies one item to the shadow queues, returns its result.
  function automatic result_t merge_step(input bus_item_t it);
    result_t          r;
    logic             have;
    int               best;
    logic [63:0]      best_t;
    logic [PTR_W-1:0] fill;
    r      = '0;
    have   = 1'b0;
    best   = 0;
    best_t = '0;
    case (it.cmd)
      CMD_PUSH: begin
        fill = tail_ptr[it.slot] - head_ptr[it.slot];
        n_push++;
        if (int'(it.slot) >= NCH || fill >= QDEPTH) begin
          r.dropped = 1'b1;
          n_drop++;
        end else begin
          ev_mem[it.slot][tail_ptr[it.slot][PTR_W-2:0]] = it.ev;
          tail_ptr[it.slot] = tail_ptr[it.slot] + 1'b1;
        end
      end
      CMD_POP: begin
        for (int c = 0; c < NCH; c++) begin
          if (head_ptr[c] != tail_ptr[c]) begin
            if (!have || ev_mem[c][head_ptr[c][PTR_W-2:0]].begin_time < best_t) begin
              have   = 1'b1;
              best   = c;
              best_t = ev_mem[c][head_ptr[c][PTR_W-2:0]].begin_time;
            end
          end
        end
        if (have) begin
          r.found   = 1'b1;
          r.channel = best[SLOT_W-1:0];
          r.ev      = ev_mem[best][head_ptr[best][PTR_W-2:0]];
          head_ptr[best] = head_ptr[best] + 1'b1;
          n_found++;
        end else begin
          n_empty_pop++;
        end
      end
      CMD_CLEAR: begin
        for (int c = 0; c < NCH; c++) begin
          head_ptr[c] = '0;
          tail_ptr[c] = '0;
        end
        n_clear++;
      end
      default: n_rsvd++;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] pick_word();
    int unsigned m;
    m = $urandom_range(0, 9);
    if (m == 0) return '0;
    if (m == 1) return '1;
    return $urandom;
  endfunction

  // Mix of full-range keys, clustered keys (ties) and extremes.
  function automatic logic [63:0] pick_time(input logic [63:0] base);
    int unsigned m;
    m = $urandom_range(0, 9);
    if (m < 4) return {$urandom, $urandom};
    if (m < 8) return base + $urandom_range(0, 3);
    if (m == 8) return 64'(m - 8);
    return '1 - $urandom_range(0, 2);
  endfunction

  function automatic entry_t make_event(input logic [63:0] t, input logic [31:0] r,
                                        input logic [31:0] d, input logic [15:0] g,
                                        input logic [31:0] p);
    entry_t e;
    e.begin_time = t;
    e.rise_time  = r;
    e.duration   = d;
    e.ring_count = g;
    e.payload    = p;
    return e;
  endfunction

  function automatic entry_t rand_event(input logic [63:0] base);
    return make_event(pick_time(base), pick_word(), pick_word(), 16'(pick_word()),
                      pick_word());
  endfunction

  task automatic queue_item(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                            input entry_t ev, input logic hold);
    bus_item_t it;
    it.cmd  = cmd;
    it.slot = slot;
    it.ev   = ev;
    it.hold = hold;
    pending_items = {pending_items, it};
    gen_cnt++;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    err_cnt++;
    $display("MISMATCH result %0d: %s got %h want %h", res_cnt, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Input side: acceptance, prediction, cycle limit.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni && in_valid && in_ready) begin
      expected_results = {expected_results, merge_step(cur_item)};
      accepted_cnt <= accepted_cnt + 1;
    end
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               expected_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Driver.
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid && accepted_cnt != driven_cnt)) begin
      if (pending_items.size() == 0 ||
          (!quiet_window && $urandom_range(0, 99) < IDLE_PCT) ||
          (pending_items[0].hold && expected_results.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        cur_item = pending_items.pop_front();
        in_valid   <= 1'b1;
        cmd_drv    <= cur_item.cmd;
        slot_drv   <= cur_item.slot;
        time_drv   <= cur_item.ev.begin_time;
        rise_drv   <= cur_item.ev.rise_time;
        dur_drv    <= cur_item.ev.duration;
        ring_drv   <= cur_item.ev.ring_count;
        tag_drv    <= cur_item.ev.payload;
        driven_cnt <= driven_cnt + 1;
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready <= rst_ni && (quiet_window || $urandom_range(0, 99) >= IDLE_PCT);
  end

  // Monitor.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("item with no expectation, begin_time", res_time, '0);
      end else begin
        want_res = expected_results.pop_front();
        check_field("found",          64'(res_found),   64'(want_res.found));
        check_field("dropped",        64'(res_dropped), 64'(want_res.dropped));
        check_field("out_channel",    64'(res_channel), 64'(want_res.channel));
        check_field("out_begin_time", res_time,         want_res.ev.begin_time);
        check_field("out_rise_time",  64'(res_rise),    64'(want_res.ev.rise_time));
        check_field("out_duration",   64'(res_dur),     64'(want_res.ev.duration));
        check_field("out_ring_count", 64'(res_ring),    64'(want_res.ev.ring_count));
        check_field("out_payload",    64'(res_payload), 64'(want_res.ev.payload));
      end
      res_cnt <= res_cnt + 1;
    end
  end

  initial begin
    int unsigned ch, k, m, sc, i, rounds;
    logic [63:0] base;
    bit          did_fill;
    for (int c = 0; c < NCH; c++) begin
      head_ptr[c] = '0;
      tail_ptr[c] = '0;
    end

    // Directed part.
    queue_item(CMD_POP, '1, make_event('1, '1, '1, '1, '1), 1'b0);
    queue_item(CMD_RESERVED, '1, make_event('1, '1, '1, '1, '1), 1'b0);
    queue_item(CMD_CLEAR, '0, make_event('0, '0, '0, '0, '0), 1'b0);
    queue_item(CMD_PUSH, 3'd0, make_event('1, '1, '1, '1, '1), 1'b0);
    queue_item(CMD_PUSH, 3'd7, make_event('0, '0, '0, '0, '0), 1'b0);
    queue_item(CMD_PUSH, 3'd3, make_event(64'd5, 32'h0000_0003, 32'hffff_0000, 16'h5a5a,
                                          32'h1234_5678), 1'b0);
    queue_item(CMD_PUSH, 3'd1, make_event(64'd5, 32'hdead_beef, 32'h0000_ffff, 16'ha5a5,
                                          32'h8765_4321), 1'b0);
    queue_item(CMD_POP, '0, make_event('0, '0, '0, '0, '0), 1'b1);
    queue_item(CMD_POP, '0, rand_event('0), 1'b0);
    queue_item(CMD_POP, '0, rand_event('0), 1'b0);
    queue_item(CMD_POP, '0, rand_event('0), 1'b0);
    queue_item(CMD_POP, '0, rand_event('0), 1'b0);
    // Queue order is arrival order, not key order.
    queue_item(CMD_PUSH, 3'd2, make_event(64'd10, 32'd1, 32'd2, 16'd3, 32'd4), 1'b0);
    queue_item(CMD_PUSH, 3'd2, make_event(64'd3, 32'd5, 32'd6, 16'd7, 32'd8), 1'b0);
    queue_item(CMD_PUSH, 3'd4, make_event(64'd7, 32'd9, 32'd10, 16'd11, 32'd12), 1'b0);
    queue_item(CMD_POP, '0, rand_event('0), 1'b0);
    queue_item(CMD_POP, '0, rand_event('0), 1'b0);
    queue_item(CMD_POP, '0, rand_event('0), 1'b0);
    queue_item(CMD_PUSH, 3'd5, rand_event('0), 1'b0);
    queue_item(CMD_CLEAR, '1, rand_event('1), 1'b0);
    queue_item(CMD_POP, '0, rand_event('0), 1'b0);
    queue_item(CMD_RESERVED, 3'd2, rand_event('0), 1'b0);

    // Random part.
    did_fill = 1'b0;
    while (gen_cnt < RAND_ITEMS + 22) begin
      sc = $urandom_range(0, 99);
      if (!did_fill || sc < 2) begin
        // Fill one queue past full, drain most of it, fill again: drops and pointer wrap.
        did_fill = 1'b1;
        ch = $urandom_range(0, NCH - 1);
        base = {$urandom, $urandom};
        for (rounds = 0; rounds < 2; rounds++) begin
          for (i = 0; i < QDEPTH + 2; i++)
            queue_item(CMD_PUSH, ch[SLOT_W-1:0], rand_event(base), 1'b0);
          m = $urandom_range(QDEPTH - 8, QDEPTH + 2);
          for (i = 0; i < m; i++)
            queue_item(CMD_POP, SLOT_W'($urandom), rand_event(base), 1'b0);
        end
      end else if (sc < 8) begin
        queue_item(CMD_CLEAR, SLOT_W'($urandom), rand_event('0), 1'b0);
      end else if (sc < 14) begin
        k = $urandom_range(1, 4);
        for (i = 0; i < k; i++)
          queue_item(CMD_W'($urandom), SLOT_W'($urandom), rand_event({$urandom, $urandom}),
                     1'b0);
      end else begin
        k = $urandom_range(1, 12);
        base = {$urandom, $urandom};
        for (i = 0; i < k; i++)
          queue_item(CMD_PUSH, SLOT_W'($urandom), rand_event(base),
                     (i == 0) && ($urandom_range(0, 7) == 0));
        m = $urandom_range(1, k + 3);
        for (i = 0; i < m; i++)
          queue_item(CMD_POP, SLOT_W'($urandom), rand_event(base), 1'b0);
      end
    end

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() != 0 || accepted_cnt != driven_cnt ||
           expected_results.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Covered %0d items: %0d pushes (%0d refused), %0d pops returning events,",
             accepted_cnt, n_push, n_drop, n_found);
    $display("  %0d pops on empty queues, %0d clears, %0d reserved commands; %0d mismatches",
             n_empty_pop, n_clear, n_rsvd, err_cnt);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/tocm_pkg.sv
hdl/tocm_ram.sv
hdl/tocm_ptrs.sv
hdl/timestamp_ordered_channel_merge.sv
hdl/tocm_checker.sv
tb/timestamp_ordered_channel_merge_tb.sv
